[hw/rtl/wrpd_pkg.sv]
// ----------------------------------------------------------------------------
// wrpd_pkg
// Word types and fixed field widths shared by the window repeat detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wrpd_pkg;

  localparam int SIG_TAG_W = 32;
  localparam int STEP_W    = 16;

  typedef struct packed {
    logic [SIG_TAG_W-1:0] sig_tag;
    logic                 sig_present;
    logic [STEP_W-1:0]    step_number;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        slot_used;
    logic              prior_found;
    logic [3:0]        prior_slot;
    logic [STEP_W-1:0] prior_step;
    logic [2:0]        cycle_period;
    logic [4:0]        cycle_reps;
  } out_word_t;

endpackage

`default_nettype wire

[hw/rtl/wrpd_in_if.sv]
// ----------------------------------------------------------------------------
// wrpd_in_if
// Valid/ready channel carrying one pushed signature word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrpd_in_if;
  logic               valid;
  logic               ready;
  wrpd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/wrpd_out_if.sv]
// ----------------------------------------------------------------------------
// wrpd_out_if
// Valid/ready channel carrying one detector result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrpd_out_if;
  logic                valid;
  logic                ready;
  wrpd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/wrpd_ram.sv]
// ----------------------------------------------------------------------------
// wrpd_ram
// Window store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 49
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hw/rtl/wrpd_cmp.sv]
// ----------------------------------------------------------------------------
// wrpd_cmp
// Shared tag comparator: two entries match when both are present and equal.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpd_cmp #(
  parameter int TW = 32
) (
  input  wire logic          valid_a,
  input  wire logic [TW-1:0] tag_a,
  input  wire logic          valid_b,
  input  wire logic [TW-1:0] tag_b,
  output logic               match
);

  assign match = valid_a && valid_b && (tag_a == tag_b);

endmodule

`default_nettype wire

[hw/rtl/window_repeat_period_detector.sv]
// ----------------------------------------------------------------------------
// window_repeat_period_detector
// Ring window of signature tags with newest-prior lookup and period search.
// ----------------------------------------------------------------------------
// usage:
//   din  : one word per push (tag, present flag, step number), valid/ready.
//   dout : one result word per push (slot written, newest earlier match,
//          smallest repeating period and its repetition count), valid/ready.
// each pushed word is written into the window ring in the cycle it is
// accepted; a sequencer then walks the window through one comparator, two
// reads a step, and each comparison has an address state and a compare
// state. the prior search makes up to fill-1 comparisons, then come the
// period and repeat blocks, with a period or repeat bound check before
// each block; din is not ready meanwhile.
// results go through an output register, so a stalled dout does not block
// the next push: the block only waits at the end of an item if the
// previous result has not yet been taken.
// reset (rst, synchronous) empties the window and drops any pending result;
// window contents are not cleared, only the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module window_repeat_period_detector #(
  parameter int WINDOW_DEPTH = 16,
  parameter int MAX_PERIOD   = 4,
  parameter int TAG_WIDTH    = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  wrpd_in_if.sink    din,
  wrpd_out_if.source dout
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int PW = $clog2(MAX_PERIOD + 2);
  localparam int XW = CW + PW + 1;
  localparam int SW = (TAG_WIDTH < wrpd_pkg::SIG_TAG_W) ? TAG_WIDTH : wrpd_pkg::SIG_TAG_W;
  localparam int EW = SW + 1 + wrpd_pkg::STEP_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PRI_RD   = 3'd1;
  localparam logic [2:0] S_PRI_CMP  = 3'd2;
  localparam logic [2:0] S_PER_TEST = 3'd3;
  localparam logic [2:0] S_BLK_RD   = 3'd4;
  localparam logic [2:0] S_BLK_CMP  = 3'd5;
  localparam logic [2:0] S_REP_TEST = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  logic [2:0]                  state;
  logic [AW-1:0]               wp;
  logic [CW-1:0]               fill;
  logic [CW-1:0]               fill_inc;
  logic [AW-1:0]               cur_slot;
  logic [AW-1:0]               back_a;
  logic [AW-1:0]               back_b;
  logic [PW-1:0]               p;
  logic [CW-1:0]               off;
  logic [CW-1:0]               reps;
  logic                        rep_mode;
  logic                        per_hit;
  logic                        found;
  logic [AW-1:0]               pslot;
  logic [wrpd_pkg::STEP_W-1:0] pstep;

  logic                        acc;
  logic [AW-1:0]               raddr_a;
  logic [AW-1:0]               raddr_b;
  logic [EW-1:0]               wdata;
  logic [EW-1:0]               rdata_a;
  logic [EW-1:0]               rdata_b;
  logic                        match;

  // slot holding the entry 'back' places before the newest one
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] back);
    logic [AW:0] diff;
    diff = {1'b0, base} - {1'b0, back};
    if (back > base) begin
      diff = {1'b0, base} + (AW+1)'(WINDOW_DEPTH) - {1'b0, back};
    end
    return diff[AW-1:0];
  endfunction

  assign din.ready = (state == S_IDLE);
  assign acc       = din.valid && din.ready;
  assign fill_inc  = (fill == CW'(WINDOW_DEPTH)) ? fill : fill + CW'(1);
  assign wdata     = {din.data.sig_present, din.data.sig_tag[SW-1:0],
                      din.data.step_number};
  assign raddr_a   = slot_of(cur_slot, back_a);
  assign raddr_b   = slot_of(cur_slot, back_b);

  wrpd_ram #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .we      (acc),
    .waddr   (wp),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  wrpd_cmp #(
    .TW (SW)
  ) u_cmp (
    .valid_a (rdata_a[EW-1]),
    .tag_a   (rdata_a[EW-2:wrpd_pkg::STEP_W]),
    .valid_b (rdata_b[EW-1]),
    .tag_b   (rdata_b[EW-2:wrpd_pkg::STEP_W]),
    .match   (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wp         <= '0;
      fill       <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!dout.valid || dout.ready)) begin
        dout.valid <= 1'b1;
      end else if (dout.valid && dout.ready) begin
        dout.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cur_slot <= wp;
            wp       <= (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + AW'(1);
            fill     <= fill_inc;
            found    <= 1'b0;
            pslot    <= '0;
            pstep    <= '0;
            per_hit  <= 1'b0;
            reps     <= '0;
            p        <= PW'(1);
            back_a   <= '0;
            back_b   <= AW'(1);
            if (din.data.sig_present && fill_inc >= CW'(2)) begin
              state <= S_PRI_RD;
            end else begin
              state <= S_PER_TEST;
            end
          end
        end
        S_PRI_RD: begin
          state <= S_PRI_CMP;
        end
        S_PRI_CMP: begin
          if (match) begin
            found <= 1'b1;
            pslot <= raddr_b;
            pstep <= rdata_b[wrpd_pkg::STEP_W-1:0];
            state <= S_PER_TEST;
          end else if (XW'(back_b) + XW'(1) >= XW'(fill)) begin
            state <= S_PER_TEST;
          end else begin
            back_b <= back_b + AW'(1);
            state  <= S_PRI_RD;
          end
        end
        S_PER_TEST: begin
          // try period p against the p words just before the newest p
          if (XW'(p) <= XW'(MAX_PERIOD) && (XW'(p) << 1) <= XW'(fill)) begin
            off      <= CW'(p);
            back_a   <= '0;
            back_b   <= AW'(p);
            rep_mode <= 1'b0;
            state    <= S_BLK_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_BLK_RD: begin
          state <= S_BLK_CMP;
        end
        S_BLK_CMP: begin
          if (!match) begin
            if (rep_mode) begin
              state <= S_OUT;
            end else begin
              p     <= p + PW'(1);
              state <= S_PER_TEST;
            end
          end else if (XW'(back_a) + XW'(1) == XW'(p)) begin
            per_hit  <= 1'b1;
            reps     <= rep_mode ? reps + CW'(1) : CW'(2);
            off      <= off + CW'(p);
            rep_mode <= 1'b1;
            state    <= S_REP_TEST;
          end else begin
            back_a <= back_a + AW'(1);
            back_b <= back_b + AW'(1);
            state  <= S_BLK_RD;
          end
        end
        S_REP_TEST: begin
          // another whole block of the period must fit inside the fill
          if (XW'(off) + XW'(p) <= XW'(fill)) begin
            back_a <= '0;
            back_b <= AW'(off);
            state  <= S_BLK_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!dout.valid || dout.ready) begin
            dout.data.slot_used    <= 4'(cur_slot);
            dout.data.prior_found  <= found;
            dout.data.prior_slot   <= 4'(pslot);
            dout.data.prior_step   <= pstep;
            dout.data.cycle_period <= per_hit ? 3'(p) : 3'd0;
            dout.data.cycle_reps   <= per_hit ? 5'(reps) : 5'd0;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // busy straight after every accepted word
  a_busy_after_push: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> !din.ready)
    else $error("din ready straight after an accepted word");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_no_prior_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.data.prior_found |->
      dout.data.prior_slot == 4'd0 && dout.data.prior_step == '0)
    else $error("prior fields set without a prior match");

  a_reps_min: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && per_hit |-> reps >= CW'(2))
    else $error("period reported with fewer than two repetitions");

endmodule

`default_nettype wire

[tb/wrpd_checker.sv]
// ----------------------------------------------------------------------------
// wrpd_checker
// Watches both channels of the window repeat detector and predicts every
// result word from its own copy of the window. Each accepted result is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wrpd_checker (
  input  logic       clk,
  input  logic       rst,
  wrpd_in_if         din,
  wrpd_out_if        dout,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int MAXP  = 4;

  // shadow copy of the window
  logic [wrpd_pkg::SIG_TAG_W-1:0] tag_mem [DEPTH];
  bit                             tag_ok  [DEPTH];
  logic [wrpd_pkg::STEP_W-1:0]    step_mem[DEPTH];
  int                             wr_ptr;
  int                             fill;

  wrpd_pkg::out_word_t            predicted_q[$];
  wrpd_pkg::out_word_t            want;
  int                             n_bad;
  int                             n_wait;
  int                             n_seen;

  assign fail_count = n_bad;
  assign pending    = n_wait;

  initial begin
    n_bad  = 0;
    n_wait = 0;
    n_seen = 0;
    wr_ptr = 0;
    fill   = 0;
  end

  task automatic report_bad(input string what, input longint got, input longint exp_v);
    $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h", n_seen, what, got, exp_v);
    n_bad++;
  endtask

  // slot holding the entry 'b' places before the newest
  function automatic int back_slot(input int b);
    return (wr_ptr + 2 * DEPTH - 1 - b) % DEPTH;
  endfunction

  function automatic bit same_entry(input int a, input int b);
    return tag_ok[a] && tag_ok[b] && tag_mem[a] == tag_mem[b];
  endfunction

  // newest p entries equal the p entries lying off entries earlier
  function automatic bit run_equal(input int p, input int off);
    for (int j = 0; j < p; j++) begin
      if (!same_entry(back_slot(j), back_slot(j + off))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic wrpd_pkg::out_word_t predict_push(input wrpd_pkg::in_word_t w);
    wrpd_pkg::out_word_t r;
    int        slot;
    int        idx;
    int        reps;
    bit        hit;
    bit        got_period;
    r    = '0;
    slot = wr_ptr;
    tag_mem[slot]  = w.sig_tag;
    tag_ok[slot]   = w.sig_present;
    step_mem[slot] = w.step_number;
    wr_ptr = (slot + 1) % DEPTH;
    if (fill < DEPTH) fill++;
    r.slot_used = slot[3:0];

    // newest earlier entry with the same tag, skipping the one just written
    hit = 1'b0;
    if (w.sig_present) begin
      for (int i = 1; i < fill && !hit; i++) begin
        idx = back_slot(i);
        if (tag_ok[idx] && tag_mem[idx] == w.sig_tag) begin
          hit           = 1'b1;
          r.prior_found = 1'b1;
          r.prior_slot  = idx[3:0];
          r.prior_step  = step_mem[idx];
        end
      end
    end

    got_period = 1'b0;
    for (int p = 1; p <= MAXP && 2 * p <= fill && !got_period; p++) begin
      if (run_equal(p, p)) begin
        got_period = 1'b1;
        reps = 2;
        for (int k = 2; (k + 1) * p <= fill; k++) begin
          if (!run_equal(p, k * p)) break;
          reps++;
        end
        r.cycle_period = p[2:0];
        r.cycle_reps   = reps[4:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wr_ptr = 0;
      fill   = 0;
      predicted_q.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        if (predicted_q.size() == 0) begin
          report_bad("unexpected result word", dout.data, 0);
        end else begin
          want = predicted_q.pop_front();
          if (dout.data.slot_used !== want.slot_used)
            report_bad("slot_used", dout.data.slot_used, want.slot_used);
          if (dout.data.prior_found !== want.prior_found)
            report_bad("prior_found", dout.data.prior_found, want.prior_found);
          if (dout.data.prior_slot !== want.prior_slot)
            report_bad("prior_slot", dout.data.prior_slot, want.prior_slot);
          if (dout.data.prior_step !== want.prior_step)
            report_bad("prior_step", dout.data.prior_step, want.prior_step);
          if (dout.data.cycle_period !== want.cycle_period)
            report_bad("cycle_period", dout.data.cycle_period, want.cycle_period);
          if (dout.data.cycle_reps !== want.cycle_reps)
            report_bad("cycle_reps", dout.data.cycle_reps, want.cycle_reps);
        end
        n_seen++;
      end
      if (din.valid && din.ready) predicted_q.push_back(predict_push(din.data));
    end
    n_wait = predicted_q.size();
  end

endmodule

[tb/tb_window_repeat_period_detector.sv]
// ----------------------------------------------------------------------------
// tb_window_repeat_period_detector
// Drives signature words into the window repeat detector: a directed set of
// tag, presence and period cases, then random repeating sequences with noise
// and broken repeats, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_window_repeat_period_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS        = 1300;
  localparam int QUIET_ITEMS    = 120;
  localparam int DRAIN_EVERY    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 200;

  logic clk = 1'b0;
  logic rst;

  wrpd_in_if  din_if();
  wrpd_out_if dout_if();

  int fail_count;
  int pending;

  bit                          quiet;
  int                          send_odds;
  int                          n_sent;
  logic [wrpd_pkg::STEP_W-1:0] step_ctr;
  int                          idle_cycles;

  always #5 clk = ~clk;

  window_repeat_period_detector u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  wrpd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .din        (din_if),
    .dout       (dout_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // stall on the result side, in bursts, with calm stretches between
  initial begin
    int odds;
    int span;
    int g;
    dout_if.ready = 1'b0;
    odds = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = $urandom_range(20, 150);
        odds = $urandom_range(0, 3);
      end
      span--;
      if (!quiet && $urandom_range(0, 9) < odds * 2) begin
        g = $urandom_range(1, 3);
        dout_if.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  // no word moving on either side for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [wrpd_pkg::STEP_W-1:0] next_step();
    logic [31:0] rnd;
    rnd = $urandom;
    if ($urandom_range(0, 15) == 0) step_ctr = rnd[wrpd_pkg::STEP_W-1:0];
    else step_ctr = step_ctr + 1'b1;
    return step_ctr;
  endfunction

  task automatic push_word(input logic [wrpd_pkg::SIG_TAG_W-1:0] tag, input bit present,
                           input logic [wrpd_pkg::STEP_W-1:0] step);
    wrpd_pkg::in_word_t w;
    int                 gap;
    w.sig_tag     = tag;
    w.sig_present = present;
    w.step_number = step;
    if (!quiet && $urandom_range(0, 9) < send_odds * 2) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      din_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    din_if.valid <= 1'b1;
    din_if.data  <= w;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    n_sent++;
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [wrpd_pkg::SIG_TAG_W-1:0] pool  [5];
    logic [wrpd_pkg::SIG_TAG_W-1:0] recent[8];
    logic [wrpd_pkg::SIG_TAG_W-1:0] t;
    bit                             pres;
    int                             kind;
    int                             plen;
    int                             nrep;
    int                             bad_at;
    int                             b;
    int                             rec_idx;
    int                             next_drain;
    int                             k;

    rst           = 1'b1;
    din_if.valid  = 1'b0;
    din_if.data   = '0;
    quiet         = 1'b0;
    send_odds     = 1;
    n_sent        = 0;
    step_ctr      = '0;
    rec_idx       = 0;
    next_drain    = DRAIN_EVERY;
    for (int i = 0; i < 8; i++) recent[i] = $urandom;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // tag and step extremes, absent entry between two equal tags
    push_word(32'h0000_0000, 1'b1, 16'h0000);
    push_word(32'h0000_0000, 1'b1, 16'hFFFF);
    push_word(32'hFFFF_FFFF, 1'b1, 16'h1234);
    push_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
    push_word(32'hFFFF_FFFF, 1'b1, 16'h0001);
    // period two, three and four
    for (int i = 0; i < 4; i++)
      push_word((i % 2) ? 32'hA5A5_0001 : 32'h5A5A_0002, 1'b1, next_step());
    for (int i = 0; i < 6; i++) push_word(32'h0C0C_0000 + (i % 3), 1'b1, next_step());
    for (int i = 0; i < 8; i++) push_word(32'h00F0_0F00 + (i % 4), 1'b1, next_step());
    push_word(32'h00F0_0F00, 1'b0, next_step());

    while (n_sent < N_ITEMS) begin
      if (n_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      quiet     = (n_sent >= N_ITEMS - QUIET_ITEMS);
      send_odds = $urandom_range(0, 3);
      kind      = $urandom_range(0, 9);
      if (kind < 2) begin
        push_word($urandom, $urandom_range(0, 3) != 0, next_step());
      end else begin
        // repeating sequence, now and then with one broken word
        plen = $urandom_range(1, 5);
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(0, 2) == 0) pool[i] = recent[$urandom_range(0, 7)];
          else if (i > 0 && $urandom_range(0, 5) == 0) pool[i] = pool[0];
          else pool[i] = $urandom;
        end
        nrep   = $urandom_range(plen, (plen == 1) ? 20 : 4 * plen + 3);
        bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nrep - 1) : -1;
        for (int i = 0; i < nrep; i++) begin
          t    = pool[i % plen];
          pres = 1'b1;
          if (i == bad_at) begin
            if ($urandom_range(0, 1) == 0) begin
              pres = 1'b0;
            end else begin
              b    = $urandom_range(0, wrpd_pkg::SIG_TAG_W - 1);
              t[b] = ~t[b];
            end
          end
          push_word(t, pres, next_step());
        end
        recent[rec_idx] = pool[0];
        rec_idx = (rec_idx + 1) % 8;
      end
    end

    @(negedge clk);
    din_if.valid <= 1'b0;
    k = 0;
    while (pending != 0 && k < WATCHDOG_LIMIT) begin
      @(posedge clk);
      k++;
    end
    if (pending != 0) begin
      $display("CHECK FAILED");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (fail_count == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end

endmodule
